/* design/lla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types, register indexes and rule tables for the life-like automaton
// step core.
// ----------------------------------------------------------------------------
package lla_pkg;

  typedef enum logic [1:0] {
    RULE_LIFE      = 2'd0,
    RULE_MAZE      = 2'd1,
    RULE_MAZECTRIC = 2'd2,
    RULE_DAY_NIGHT = 2'd3
  } rule_mode_e;

  localparam logic [1:0] CFG_RULE_MODE   = 2'd0;
  localparam logic [1:0] CFG_LINE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_LINE_COUNT  = 2'd2;

  localparam int unsigned CfgDataW = 13;

  localparam logic [6:0]  LINE_LENGTH_RESET = 7'd16;
  localparam logic [12:0] LINE_COUNT_RESET  = 13'd16;
  localparam logic [12:0] LINE_COUNT_MIN    = 13'd3;
  localparam logic [12:0] LINE_COUNT_MAX    = 13'd4096;

  // Bit n set: birth / survival with n live neighbors.
  localparam logic [8:0] LIFE_BIRTH      = 9'h008;
  localparam logic [8:0] LIFE_SURVIVE    = 9'h00C;
  localparam logic [8:0] MAZE_BIRTH      = 9'h008;
  localparam logic [8:0] MAZE_SURVIVE    = 9'h03E;
  localparam logic [8:0] MAZECT_BIRTH    = 9'h008;
  localparam logic [8:0] MAZECT_SURVIVE  = 9'h01E;
  localparam logic [8:0] DN_BIRTH        = 9'h1C8;
  localparam logic [8:0] DN_SURVIVE      = 9'h1D8;

  // Window bit layout: col*3 + row, center at bit 4.
  function automatic logic judge(rule_mode_e mode, logic [8:0] win);
    logic [3:0] n;
    logic [8:0] birth;
    logic [8:0] survive;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n = n + {3'b000, win[i]};
      end
    end
    case (mode)
      RULE_LIFE: begin
        birth   = LIFE_BIRTH;
        survive = LIFE_SURVIVE;
      end
      RULE_MAZE: begin
        birth   = MAZE_BIRTH;
        survive = MAZE_SURVIVE;
      end
      RULE_MAZECTRIC: begin
        birth   = MAZECT_BIRTH;
        survive = MAZECT_SURVIVE;
      end
      default: begin
        birth   = DN_BIRTH;
        survive = DN_SURVIVE;
      end
    endcase
    return win[4] ? survive[n] : birth[n];
  endfunction

endpackage

/* design/lla_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lla_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/life_like_automaton_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_step_core
// One generation step of a life-like cellular automaton over a scanned grid.
// ----------------------------------------------------------------------------
// Cells enter in scan order, one per cycle while in_stall_o is low; the
// result of a cell leaves line_length+1 transfers after the cell itself.
// After the last grid cell, line_length+1 drain transfers push out the
// remaining results; the final one carries last_cell. Both line stores
// share one RAM word per column, read one position ahead so the window
// update and rule lookup happen in the same cycle as the cell transfer.
// A two-deep output stage lets input keep flowing while a result waits.
// Writing line_length or line_count restarts the generation; rule_mode
// takes effect on the next result.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core
  import lla_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cell_alive_i,
  input  logic                drain_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                next_alive_o,
  output logic                last_cell_o
);

  localparam int unsigned PosW = $clog2(LINE_MAX);
  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam int unsigned LW   = (LenW > 7) ? LenW : 7;

  rule_mode_e     rule_mode_q;
  logic [6:0]     line_length_q;
  logic [12:0]    line_count_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [12:0]    row_q, row_d;
  logic [8:0]     win_q, win_d;

  logic           out_valid_q, skid_valid_q;
  logic [1:0]     out_data_q, skid_data_q;

  logic [LW-1:0]  eff_len;
  logic [12:0]    eff_cnt;
  logic [LW-1:0]  pos_inc;
  logic           in_xfer, item_go, row_lt_cnt, pos_zero;
  logic           bottom, top, mid;
  logic [2:0]     column;
  logic [8:0]     win_shift, judge_win;
  logic           emit, res_valid, res_last, res_next;
  logic           geom_write, restart;
  logic           out_take;
  logic [1:0]     ram_rdata, ram_wdata;

  always_comb begin
    if (line_length_q < 7'd3) begin
      eff_len = LW'(3);
    end else if (LW'(line_length_q) > LW'(LINE_MAX)) begin
      eff_len = LW'(LINE_MAX);
    end else begin
      eff_len = LW'(line_length_q);
    end
    if (line_count_q < LINE_COUNT_MIN) begin
      eff_cnt = LINE_COUNT_MIN;
    end else if (line_count_q > LINE_COUNT_MAX) begin
      eff_cnt = LINE_COUNT_MAX;
    end else begin
      eff_cnt = line_count_q;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign row_lt_cnt = row_q < eff_cnt;
  assign item_go    = in_xfer && !(row_lt_cnt && drain_i);
  assign pos_zero   = pos_q == '0;
  assign pos_inc    = LW'(pos_q) + LW'(1);

  // RAM word: bit 1 older line, bit 0 newer line.
  assign bottom    = row_lt_cnt ? cell_alive_i : 1'b0;
  assign top       = (row_q >= 13'd2) ? ram_rdata[1] : 1'b0;
  assign mid       = (row_q != 13'd0) ? ram_rdata[0] : 1'b0;
  assign column    = {bottom, mid, top};
  assign ram_wdata = {ram_rdata[0], bottom};
  assign win_shift = {column, win_q[8:3]};

  always_comb begin
    if (pos_zero) begin
      judge_win = {3'b000, win_q[8:3]};
      emit      = row_q >= 13'd2;
    end else begin
      judge_win = win_shift;
      emit      = row_q != 13'd0;
    end
  end

  assign res_valid  = item_go && emit;
  assign res_next   = judge(rule_mode_q, judge_win);
  assign res_last   = pos_zero && (row_q == 13'(eff_cnt + 13'd1));
  assign geom_write = cfg_we_i &&
                      ((cfg_idx_i == CFG_LINE_LENGTH) || (cfg_idx_i == CFG_LINE_COUNT));
  assign restart    = geom_write || (res_valid && res_last);

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    win_d = win_q;
    if (item_go) begin
      win_d = pos_zero ? {column, 6'b000000} : win_shift;
      if (pos_inc >= eff_len) begin
        pos_d = '0;
        row_d = row_q + 13'd1;
      end else begin
        pos_d = PosW'(pos_inc);
      end
    end
    if (restart) begin
      pos_d = '0;
      row_d = '0;
      win_d = '0;
    end
  end

  lla_ram #(
    .WIDTH (2),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (item_go),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (pos_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_mode_q   <= RULE_LIFE;
      line_length_q <= LINE_LENGTH_RESET;
      line_count_q  <= LINE_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RULE_MODE:   rule_mode_q   <= rule_mode_e'(cfg_wdata_i[1:0]);
        CFG_LINE_LENGTH: line_length_q <= cfg_wdata_i[6:0];
        CFG_LINE_COUNT:  line_count_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  // Output register plus skid entry.
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_data_q <= {res_next, res_last};
      end else begin
        out_data_q <= {res_next, res_last};
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = out_data_q[1];
  assign last_cell_o  = out_data_q[0];

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(pos_q) < eff_len)
    else $error("position past end of line");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= 13'(eff_cnt + 13'd1))
    else $error("line number past drain region");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_last) |=> (pos_q == '0 && row_q == 13'd0 && win_q == 9'd0))
    else $error("generation not restarted after final result");
`endif

endmodule

/* tb/life_like_automaton_step_core_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_step_core_chk
// Scoreboard for the life-like automaton step core.
// ----------------------------------------------------------------------------
// Watches register writes and both channels. On every cell transfer it
// advances its own model of the line stores and the 3x3 window, queues the
// next-generation cell that falls out, and checks each output transfer
// against the oldest queued cell. Failures and the queue depth are handed up.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core_chk
  import lla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                cell_alive_i,
  input  logic                drain_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                next_alive_i,
  input  logic                last_cell_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned GridCols = 64;

  typedef struct packed {
    logic next_alive;
    logic last_cell;
  } gen_cell_t;

  gen_cell_t           next_gen_q[$];
  logic [GridCols-1:0] older_line;
  logic [GridCols-1:0] newer_line;
  logic [8:0]          window;
  int unsigned         col;
  int unsigned         row;
  int unsigned         cells_out;
  rule_mode_e          rule;
  logic [6:0]          len_reg;
  logic [12:0]         lines_reg;

  function automatic logic rule_outcome(rule_mode_e mode, logic [8:0] win);
    int unsigned n;
    logic alive;
    n = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n += win[i];
    end
    alive = win[4];
    case (mode)
      RULE_LIFE:      return (n == 3) || (alive && n == 2);
      RULE_MAZE:      return (n == 3) || (alive && n >= 1 && n <= 5);
      RULE_MAZECTRIC: return (n == 3) || (alive && n >= 1 && n <= 4);
      default:        return alive ? (n == 3 || n == 4 || n >= 6) : (n == 3 || n >= 6);
    endcase
  endfunction

  function automatic int unsigned grid_len();
    if (len_reg < 3) return 3;
    if (len_reg > GridCols) return GridCols;
    return len_reg;
  endfunction

  function automatic int unsigned grid_lines();
    if (lines_reg < 3) return 3;
    if (lines_reg > 4096) return 4096;
    return lines_reg;
  endfunction

  task automatic restart_grid();
    window    = '0;
    col       = 0;
    row       = 0;
    cells_out = 0;
  endtask

  task automatic advance_grid(input logic cell_val, input logic drn);
    int unsigned len;
    int unsigned lines;
    logic        bottom;
    logic        top_c;
    logic        mid_c;
    logic        emit;
    logic        outcome;
    logic        last;
    len     = grid_len();
    lines   = grid_lines();
    emit    = 1'b0;
    outcome = 1'b0;
    if (row < lines) begin
      if (drn) return;
      bottom = cell_val;
    end else begin
      bottom = 1'b0;
    end
    top_c = (row >= 2) ? older_line[col] : 1'b0;
    mid_c = (row >= 1) ? newer_line[col] : 1'b0;
    older_line[col] = newer_line[col];
    newer_line[col] = bottom;
    if (col == 0) begin
      if (row >= 2) begin
        outcome = rule_outcome(rule, {3'b000, window[8:3]});
        emit    = 1'b1;
      end
      window = {bottom, mid_c, top_c, 6'b000000};
    end else begin
      window = {bottom, mid_c, top_c, window[8:3]};
      if (row >= 1) begin
        outcome = rule_outcome(rule, window);
        emit    = 1'b1;
      end
    end
    col++;
    if (col >= len) begin
      col = 0;
      row++;
    end
    if (emit) begin
      cells_out++;
      last = (cells_out >= len * lines);
      next_gen_q.push_back('{next_alive: outcome, last_cell: last});
      if (last) restart_grid();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gen_cell_t exp_cell;
    if (!rst_ni) begin
      next_gen_q.delete();
      older_line   = '0;
      newer_line   = '0;
      rule         = RULE_LIFE;
      len_reg      = LINE_LENGTH_RESET;
      lines_reg    = LINE_COUNT_RESET;
      restart_grid();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RULE_MODE: rule = rule_mode_e'(cfg_wdata_i[1:0]);
          CFG_LINE_LENGTH: begin
            len_reg = cfg_wdata_i[6:0];
            restart_grid();
          end
          CFG_LINE_COUNT: begin
            lines_reg = cfg_wdata_i[12:0];
            restart_grid();
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (next_gen_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected transfer, expected none, actual next_alive %0b last_cell %0b",
                   $time, next_alive_i, last_cell_i);
        end else begin
          exp_cell = next_gen_q.pop_front();
          if (next_alive_i !== exp_cell.next_alive) begin
            fail_count_o++;
            $display("%0t: next_alive expected %0b actual %0b",
                     $time, exp_cell.next_alive, next_alive_i);
          end
          if (last_cell_i !== exp_cell.last_cell) begin
            fail_count_o++;
            $display("%0t: last_cell expected %0b actual %0b",
                     $time, exp_cell.last_cell, last_cell_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) advance_grid(cell_alive_i, drain_i);
      pending_o = next_gen_q.size();
    end
  end

endmodule

/* tb/life_like_automaton_step_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_step_core_tb
// Stimulus and verdict for the life-like automaton step core.
// ----------------------------------------------------------------------------
// Streams whole generations of random density over many grid shapes and all
// four rules, with early drains, late cells and abandoned generations mixed
// in. The sender works in bursts, the receiver stalls on its own pattern and
// now and then holds off long enough to back the core up. Checking is done
// by the scoreboard instance beside the core.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core_tb;
  import lla_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned TargetCells = 1350;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                cell_alive_i;
  logic                drain_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                next_alive_o;
  logic                last_cell_o;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned burst_left;
  int unsigned cells_sent;
  int unsigned cols_set;
  int unsigned lines_set;

  life_like_automaton_step_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_alive_i (cell_alive_i),
    .drain_i      (drain_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .last_cell_o  (last_cell_o)
  );

  life_like_automaton_step_core_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cell_alive_i (cell_alive_i),
    .drain_i      (drain_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_i (next_alive_o),
    .last_cell_i  (last_cell_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic cell_val, input logic drn);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    cell_alive_i <= cell_val;
    drain_i      <= drn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Block drained and quiet: safe point for register writes.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_LINE_LENGTH) begin
      cols_set = (data[6:0] < 3) ? 3 : (data[6:0] > 64) ? 64 : data[6:0];
    end else if (idx == CFG_LINE_COUNT) begin
      lines_set = (data < 3) ? 3 : (data > 4096) ? 4096 : data;
    end
    @(negedge clk_i);
  endtask

  // Sends the grid in scan order, then drains; a short 'cut' abandons it.
  task automatic run_generation(input int unsigned density, input int unsigned cut);
    int unsigned total;
    logic        stray;
    total = cols_set * lines_set;
    for (int unsigned i = 0; i < total && i < cut; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        stray = 1'($urandom_range(0, 1));
        send_item(stray, 1'b1);
      end
      send_item($urandom_range(0, 99) < density, 1'b0);
      cells_sent++;
    end
    if (cut >= total) begin
      for (int unsigned j = 0; j <= cols_set; j++) begin
        stray = 1'($urandom_range(0, 1));
        send_item(stray, $urandom_range(0, 3) != 0);
        cells_sent++;
      end
    end
  endtask

  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold;
    cyc         = 0;
    mode        = 0;
    mode_left   = 0;
    hold        = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold == 0 && cyc % 3000 == 1200) hold = 300;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned gens;
    int unsigned total;
    int unsigned cut;
    int unsigned density;
    logic        reshape;
    logic [12:0] len_val;
    logic [12:0] lines_val;
    phase        = 0;
    reshape      = 1'b0;
    burst_left   = 0;
    cells_sent   = 0;
    cols_set     = LINE_LENGTH_RESET;
    lines_set    = LINE_COUNT_RESET;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_RULE_MODE;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    cell_alive_i <= 1'b0;
    drain_i      <= 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry, partial grid, then abandoned by the writes below
    run_generation(50, 20);
    settle();

    // smallest grid, all alive, with early drain and late cell
    write_reg(CFG_LINE_LENGTH, 13'd3);
    write_reg(CFG_LINE_COUNT, 13'd3);
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_RULE_MODE, {11'd0, RULE_LIFE});
    send_item(1'b1, 1'b1);
    repeat (9) send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);

    while (cells_sent < TargetCells) begin
      settle();
      write_reg(CFG_RULE_MODE, {11'($urandom_range(0, 2047)), phase[1:0]});
      if (phase == 4) begin
        len_val   = {6'($urandom_range(0, 63)), 7'($urandom_range(0, 3))};
        lines_val = $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
        write_reg(CFG_LINE_LENGTH, len_val);
        write_reg(CFG_LINE_COUNT, lines_val);
      end else if (reshape || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0:       len_val = 13'd0;
          1:       len_val = 13'd2;
          2:       len_val = 13'd3;
          3:       len_val = 13'd64;
          4:       len_val = 13'd65;
          5:       len_val = 13'd127;
          default: len_val = 13'($urandom_range(3, 12));
        endcase
        len_val[12:7] = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
          0:       lines_val = 13'd0;
          1:       lines_val = 13'd2;
          2:       lines_val = 13'd3;
          default: lines_val = 13'($urandom_range(3, 8));
        endcase
        write_reg(CFG_LINE_LENGTH, len_val);
        write_reg(CFG_LINE_COUNT, lines_val);
      end
      reshape = 1'b0;
      gens = $urandom_range(1, 3);
      for (int unsigned g = 0; g < gens; g++) begin
        if (cells_sent >= TargetCells) break;
        case ($urandom_range(0, 3))
          0:       density = 0;
          1:       density = 25;
          2:       density = 50;
          default: density = 90;
        endcase
        total = cols_set * lines_set;
        if (phase == 4) begin
          // tall grid: only the opening lines, then abandoned
          cut = 150;
        end else begin
          cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
        end
        run_generation(density, cut);
        if (cut < total) begin
          reshape = 1'b1;
          break;
        end
        if ($urandom_range(0, 2) == 0) begin
          settle();
          write_reg(CFG_RULE_MODE,
                    {11'($urandom_range(0, 2047)), 2'($urandom_range(0, 3))});
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
